// ===== sv/sapd_pkg.sv =====
// Shared types and constants for the STAP-A aggregation deframer.
// Holds the parser phase, status codes, result record and queue sizing.
// No dependencies.
package sapd_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] FORBIDDEN_BIT = 8'h80;
  localparam logic [4:0] TYPE_MASK = 5'h1F;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SIZE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_DATA    = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FORBIDDEN  = 2'd1,
    ST_TRUNC_SIZE = 2'd2,
    ST_TRUNC_NALU = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] nalu_byte;
    logic       byte_valid;
    logic       nalu_start;
    logic       nalu_end;
    logic [4:0] unit_type;
    logic [1:0] header_nri;
    logic       packet_end;
    status_t    status;
  } res_t;

endpackage

// ===== sv/sapd_front.sv =====
// Front part of the deframer: accepts payload bytes and classifies them.
// Tracks header, size and NALU phases and forms a result record for each NALU byte,
// each zero-size unit and each packet end. Depends on sapd_pkg.
module sapd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  input  logic          q_full,
  output logic          push,
  output sapd_pkg::res_t push_res
);

  sapd_pkg::phase_t phase, phase_next;
  logic [7:0]       size_high, size_high_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic             first_pending, first_pending_next;
  logic [1:0]       kept_nri, kept_nri_next;
  logic [4:0]       kept_type, kept_type_next;
  logic             accept;
  logic [15:0]      size;
  logic [4:0]       cur_type;
  logic             nalu_done;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign size     = {size_high, s_tdata};
  assign cur_type = first_pending ? (s_tdata[4:0] & sapd_pkg::TYPE_MASK) : kept_type;
  assign nalu_done = (bytes_left == 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sapd_pkg::PH_HEADER;
      size_high     <= '0;
      bytes_left    <= '0;
      first_pending <= 1'b0;
      kept_nri      <= '0;
      kept_type     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      size_high     <= size_high_next;
      bytes_left    <= bytes_left_next;
      first_pending <= first_pending_next;
      kept_nri      <= kept_nri_next;
      kept_type     <= kept_type_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    size_high_next     = size_high;
    bytes_left_next    = bytes_left;
    first_pending_next = first_pending;
    kept_nri_next      = kept_nri;
    kept_type_next     = kept_type;
    push_res           = '0;
    push_res.status    = sapd_pkg::ST_OK;
    push               = 1'b0;
    unique case (phase)
      sapd_pkg::PH_HEADER: begin
        if ((s_tdata & sapd_pkg::FORBIDDEN_BIT) != 8'h00) begin
          kept_nri_next = '0;
          if (s_tlast) begin
            push                = accept;
            push_res.packet_end = 1'b1;
            push_res.status     = sapd_pkg::ST_FORBIDDEN;
          end else begin
            phase_next = sapd_pkg::PH_DISCARD;
          end
        end else begin
          kept_nri_next = s_tdata[6:5];
          if (s_tlast) begin
            push                = accept;
            push_res.header_nri = s_tdata[6:5];
            push_res.packet_end = 1'b1;
          end else begin
            phase_next = sapd_pkg::PH_SIZE_HI;
          end
        end
      end
      sapd_pkg::PH_SIZE_HI: begin
        size_high_next = s_tdata;
        if (s_tlast) begin
          phase_next          = sapd_pkg::PH_HEADER;
          push                = accept;
          push_res.header_nri = kept_nri;
          push_res.packet_end = 1'b1;
          push_res.status     = sapd_pkg::ST_TRUNC_SIZE;
        end else begin
          phase_next = sapd_pkg::PH_SIZE_LO;
        end
      end
      sapd_pkg::PH_SIZE_LO: begin
        if (size == 16'd0) begin
          phase_next          = s_tlast ? sapd_pkg::PH_HEADER : sapd_pkg::PH_SIZE_HI;
          push                = accept;
          push_res.nalu_start = 1'b1;
          push_res.nalu_end   = 1'b1;
          push_res.header_nri = kept_nri;
          push_res.packet_end = s_tlast;
        end else if (s_tlast) begin
          phase_next          = sapd_pkg::PH_HEADER;
          push                = accept;
          push_res.header_nri = kept_nri;
          push_res.packet_end = 1'b1;
          push_res.status     = sapd_pkg::ST_TRUNC_NALU;
        end else begin
          bytes_left_next    = size;
          first_pending_next = 1'b1;
          phase_next         = sapd_pkg::PH_DATA;
        end
      end
      sapd_pkg::PH_DATA: begin
        kept_type_next      = cur_type;
        first_pending_next  = 1'b0;
        bytes_left_next     = bytes_left - 16'd1;
        push                = accept;
        push_res.nalu_byte  = s_tdata;
        push_res.byte_valid = 1'b1;
        push_res.nalu_start = first_pending;
        push_res.unit_type  = cur_type;
        push_res.header_nri = kept_nri;
        if (nalu_done) begin
          phase_next          = s_tlast ? sapd_pkg::PH_HEADER : sapd_pkg::PH_SIZE_HI;
          push_res.nalu_end   = 1'b1;
          push_res.packet_end = s_tlast;
        end else if (s_tlast) begin
          phase_next          = sapd_pkg::PH_HEADER;
          push_res.packet_end = 1'b1;
          push_res.status     = sapd_pkg::ST_TRUNC_NALU;
        end
      end
      sapd_pkg::PH_DISCARD: begin
        if (s_tlast) begin
          phase_next          = sapd_pkg::PH_HEADER;
          push                = accept;
          push_res.packet_end = 1'b1;
          push_res.status     = sapd_pkg::ST_FORBIDDEN;
        end
      end
      default: begin
        phase_next = sapd_pkg::PH_HEADER;
      end
    endcase
  end

endmodule

// ===== sv/sapd_queue.sv =====
// Short result queue between the deframer front and back parts.
// Holds classified result records so either side may stall on its own.
// Depends on sapd_pkg.
module sapd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sapd_pkg::res_t push_res,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sapd_pkg::res_t pop_res
);

  sapd_pkg::res_t                    mem [sapd_pkg::QDEPTH];
  logic [sapd_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sapd_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sapd_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  localparam logic [sapd_pkg::QPTR_W-1:0] PTR_LAST = sapd_pkg::QPTR_W'(sapd_pkg::QDEPTH - 1);
  localparam logic [sapd_pkg::QCNT_W-1:0] CNT_FULL = sapd_pkg::QCNT_W'(sapd_pkg::QDEPTH);

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_res = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/sapd_back.sv =====
// Back part of the deframer: drives the result stream from an output register.
// Pops the queue whenever it holds a record and the register is empty or being taken.
// Depends on sapd_pkg.
module sapd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  sapd_pkg::res_t q_res,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output sapd_pkg::res_t m_res
);

  assign pop = !q_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_res <= q_res;
    end
  end

endmodule

// ===== sv/stap_a_aggregation_deframer_unit.sv =====
// Splits an RTP H.264 STAP-A payload, one byte per transfer with tlast on the
// packet's final byte, into NALU bytes with start/end marks, type, NRI and a
// packet status. One byte is taken every clock while the queue is not full; the
// parser decides each byte in the cycle it arrives and a two-entry queue plus
// the output register keep input flowing while the result side stalls.
// Depends on sapd_pkg, sapd_front, sapd_queue and sapd_back.
module stap_a_aggregation_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [7:0] nalu_byte, [12:8] unit_type,
                                // [14:13] header_nri, [16:15] status, rest zero
  output logic [2:0]  m_tuser,  // [0] byte_valid, [1] nalu_start, [2] nalu_end
  output logic        m_tlast
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  sapd_pkg::res_t push_res;
  sapd_pkg::res_t q_res;
  sapd_pkg::res_t m_res;

  sapd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_res (push_res)
  );

  sapd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_res  (q_res)
  );

  sapd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_res    (q_res),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {7'd0, m_res.status, m_res.header_nri, m_res.unit_type, m_res.nalu_byte};
  assign m_tuser = {m_res.nalu_end, m_res.nalu_start, m_res.byte_valid};
  assign m_tlast = m_res.packet_end;

endmodule

// ===== bench/stap_a_aggregation_deframer_unit_test.sv =====
// Self-checking bench for stap_a_aggregation_deframer_unit: STAP-A payload bytes go in,
// NALU byte records come out and are compared against an in-bench deframer model.
// Depends on sapd_pkg and the unit under test only.
module stap_a_aggregation_deframer_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_N = 27;
  localparam int RAND_ITEMS = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam sapd_pkg::res_t NO_RES = '0;

  typedef struct packed {
    logic [7:0]     data;
    logic           last;
    logic           fixed;
    sapd_pkg::res_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  row_t           dir_tab [DIR_N];
  row_t           feed_q [$];
  sapd_pkg::res_t nalu_exp_q [$];
  int     acc_idx;
  int     cyc;
  int     errs;
  int     n_packets;
  int     n_results;
  int     n_status [4];
  bit     feed_done;

  sapd_pkg::phase_t ph;
  logic [7:0]  sz_hi;
  logic [15:0] remaining;
  logic        first_due;
  logic [1:0]  nri_keep;
  logic [4:0]  type_keep;

  stap_a_aggregation_deframer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  function automatic sapd_pkg::res_t pack_res(input logic [7:0] nb, input logic v,
                                              input logic s, input logic e,
                                              input logic [4:0] ty,
                                              input logic [1:0] nri, input logic pe,
                                              input sapd_pkg::status_t stt);
    sapd_pkg::res_t r;
    r.nalu_byte  = nb;
    r.byte_valid = v;
    r.nalu_start = s;
    r.nalu_end   = e;
    r.unit_type  = ty;
    r.header_nri = nri;
    r.packet_end = pe;
    r.status     = stt;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic lst,
                                      output sapd_pkg::res_t r);
    logic       st;
    logic [15:0] sz;
    r = NO_RES;
    sz = {sz_hi, b};
    case (ph)
      sapd_pkg::PH_HEADER: begin
        if ((b & sapd_pkg::FORBIDDEN_BIT) != 8'd0) begin
          nri_keep = 2'd0;
          if (lst) begin
            r = pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd0, 1'b1, sapd_pkg::ST_FORBIDDEN);
            return 1'b1;
          end
          ph = sapd_pkg::PH_DISCARD;
          return 1'b0;
        end
        nri_keep = b[6:5];
        if (lst) begin
          r = pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, nri_keep, 1'b1, sapd_pkg::ST_OK);
          return 1'b1;
        end
        ph = sapd_pkg::PH_SIZE_HI;
        return 1'b0;
      end
      sapd_pkg::PH_SIZE_HI: begin
        sz_hi = b;
        if (lst) begin
          ph = sapd_pkg::PH_HEADER;
          r = pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, nri_keep, 1'b1, sapd_pkg::ST_TRUNC_SIZE);
          return 1'b1;
        end
        ph = sapd_pkg::PH_SIZE_LO;
        return 1'b0;
      end
      sapd_pkg::PH_SIZE_LO: begin
        if (sz == 16'd0) begin
          ph = lst ? sapd_pkg::PH_HEADER : sapd_pkg::PH_SIZE_HI;
          r = pack_res(8'd0, 1'b0, 1'b1, 1'b1, 5'd0, nri_keep, lst, sapd_pkg::ST_OK);
          return 1'b1;
        end
        if (lst) begin
          ph = sapd_pkg::PH_HEADER;
          r = pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, nri_keep, 1'b1, sapd_pkg::ST_TRUNC_NALU);
          return 1'b1;
        end
        remaining = sz;
        first_due = 1'b1;
        ph = sapd_pkg::PH_DATA;
        return 1'b0;
      end
      sapd_pkg::PH_DATA: begin
        st = first_due;
        if (first_due) type_keep = b[4:0] & sapd_pkg::TYPE_MASK;
        first_due = 1'b0;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          ph = lst ? sapd_pkg::PH_HEADER : sapd_pkg::PH_SIZE_HI;
          r = pack_res(b, 1'b1, st, 1'b1, type_keep, nri_keep, lst, sapd_pkg::ST_OK);
        end else if (lst) begin
          ph = sapd_pkg::PH_HEADER;
          r = pack_res(b, 1'b1, st, 1'b0, type_keep, nri_keep, 1'b1, sapd_pkg::ST_TRUNC_NALU);
        end else begin
          r = pack_res(b, 1'b1, st, 1'b0, type_keep, nri_keep, 1'b0, sapd_pkg::ST_OK);
        end
        return 1'b1;
      end
      sapd_pkg::PH_DISCARD: begin
        if (lst) begin
          ph = sapd_pkg::PH_HEADER;
          r = pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd0, 1'b1, sapd_pkg::ST_FORBIDDEN);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        ph = sapd_pkg::PH_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit calm_now();
    return ((cyc / 128) % 4) == 0;
  endfunction

  task automatic push_bytes(input logic [7:0] bytes [$]);
    int i;
    row_t row;
    for (i = 0; i < bytes.size(); i++) begin
      row = {bytes[i], i == bytes.size() - 1, 1'b0, NO_RES};
      feed_q.insert(feed_q.size(), row);
    end
  endtask

  task automatic build_packet();
    logic [7:0] bytes [$];
    int kind;
    int units;
    int sz;
    int r;
    int n;
    int i;
    int u;
    bit cut;
    kind = $urandom_range(0, 99);
    cut = 1'b0;
    if (kind < 6) begin
      bytes.insert(bytes.size(), 8'($urandom_range(0, 255)) | sapd_pkg::FORBIDDEN_BIT);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    end else if (kind < 12) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    end else begin
      bytes.insert(bytes.size(), 8'($urandom_range(0, 255)) & 8'h7F);
      units = $urandom_range(0, 4);
      for (u = 0; u < units && !cut; u++) begin
        r = $urandom_range(0, 99);
        if (r < 10) sz = 0;
        else if (r < 88) sz = $urandom_range(1, 6);
        else if (r < 96) sz = $urandom_range(7, 40);
        else sz = $urandom_range(256, 65535);
        bytes.insert(bytes.size(), 8'(sz >> 8));
        bytes.insert(bytes.size(), 8'(sz));
        n = (sz > 40) ? $urandom_range(0, 8) : sz;
        for (i = 0; i < n; i++) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        if (sz > 40) cut = 1'b1;
      end
      if (!cut && kind < 30) begin
        n = $urandom_range(1, bytes.size());
        while (bytes.size() > n) void'(bytes.pop_back());
      end
    end
    push_bytes(bytes);
  endtask

  task automatic check_field(input string fld, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fld, want, got);
      errs++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("FAIL stap_a_aggregation_deframer_unit");
      $finish;
    end
  end

  initial begin
    int i;
    int gap;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'd0;
    s_tlast  <= 1'b0;
    dir_tab = '{
      {8'h80, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd0, 1'b1, sapd_pkg::ST_FORBIDDEN)},
      {8'h60, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd3, 1'b1, sapd_pkg::ST_OK)},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd0, 1'b1, sapd_pkg::ST_TRUNC_SIZE)},
      {8'hFF, 1'b0, 1'b0, NO_RES},
      {8'h34, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd0, 1'b1, sapd_pkg::ST_FORBIDDEN)},
      {8'h20, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b1,
       pack_res(8'd0, 1'b0, 1'b1, 1'b1, 5'd0, 2'd1, 1'b0, sapd_pkg::ST_OK)},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h01, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b0, 1'b0, 5'd0, 2'd1, 1'b1, sapd_pkg::ST_TRUNC_NALU)},
      {8'h40, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h02, 1'b0, 1'b0, NO_RES},
      {8'hFF, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b1, 1'b1,
       pack_res(8'd0, 1'b0, 1'b1, 1'b1, 5'd0, 2'd2, 1'b1, sapd_pkg::ST_OK)},
      {8'h7F, 1'b0, 1'b0, NO_RES},
      {8'hFF, 1'b0, 1'b0, NO_RES},
      {8'hFF, 1'b0, 1'b0, NO_RES},
      {8'hE5, 1'b0, 1'b0, NO_RES},
      {8'h1A, 1'b1, 1'b0, NO_RES},
      {8'h60, 1'b0, 1'b0, NO_RES},
      {8'h00, 1'b0, 1'b0, NO_RES},
      {8'h01, 1'b0, 1'b0, NO_RES},
      {8'h67, 1'b1, 1'b0, NO_RES}
    };
    for (i = 0; i < DIR_N; i++) feed_q.insert(feed_q.size(), dir_tab[i]);
    while (feed_q.size() < DIR_N + RAND_ITEMS) build_packet();

    @(posedge clk);
    while (rst) @(posedge clk);
    for (i = 0; i < feed_q.size(); i++) begin
      gap = pick_gap(calm_now());
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= feed_q[i].data;
      s_tlast  <= feed_q[i].last;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && n_results >= 200) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap(calm_now());
      end
    end
  end

  always @(posedge clk) begin : take_byte
    sapd_pkg::res_t r;
    bit got;
    if (rst) begin
      ph        = sapd_pkg::PH_HEADER;
      sz_hi     = 8'd0;
      remaining = 16'd0;
      first_due = 1'b0;
      nri_keep  = 2'd0;
      type_keep = 5'd0;
    end else if (s_tvalid && s_tready) begin
      got = deframe_byte(s_tdata, s_tlast, r);
      if (feed_q[acc_idx].fixed) nalu_exp_q.insert(nalu_exp_q.size(), feed_q[acc_idx].want);
      else if (got) nalu_exp_q.insert(nalu_exp_q.size(), r);
      acc_idx++;
      if (s_tlast) n_packets++;
    end
  end

  always @(posedge clk) begin : check_nalu
    sapd_pkg::res_t w;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (nalu_exp_q.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
        errs++;
      end else begin
        w = nalu_exp_q.pop_front();
        check_field("nalu_byte", w.nalu_byte, m_tdata[7:0]);
        check_field("byte_valid", w.byte_valid, m_tuser[0]);
        check_field("nalu_start", w.nalu_start, m_tuser[1]);
        check_field("nalu_end", w.nalu_end, m_tuser[2]);
        check_field("unit_type", w.unit_type, m_tdata[12:8]);
        check_field("header_nri", w.header_nri, m_tdata[14:13]);
        check_field("packet_end", w.packet_end, m_tlast);
        check_field("status", w.status, m_tdata[16:15]);
      end
      if (m_tlast) n_status[m_tdata[16:15]]++;
    end
  end

  initial begin
    errs = 0;
    acc_idx = 0;
    n_packets = 0;
    n_results = 0;
    n_status = '{0, 0, 0, 0};
    feed_done = 1'b0;
    @(posedge clk);
    while (!(feed_done && nalu_exp_q.size() == 0)) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d packets in %0d byte transfers, %0d results checked",
             n_packets, acc_idx, n_results);
    $display("packet endings: ok %0d, forbidden %0d, cut in size %0d, cut in nalu %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (errs == 0) begin
      $display("PASS stap_a_aggregation_deframer_unit");
    end else begin
      $display("FAIL stap_a_aggregation_deframer_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sapd_pkg.sv
sv/sapd_front.sv
sv/sapd_queue.sv
sv/sapd_back.sv
sv/stap_a_aggregation_deframer_unit.sv
bench/stap_a_aggregation_deframer_unit_test.sv
